/* rtl/fswg_pkg.sv */
// Shared types, constants and the throttle row table of the flapping servo wave generator.
package fswg_pkg;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_GUARD_HIGH  = 2'd0,
    CFG_GUARD_LOW   = 2'd1,
    CFG_CENTRE      = 2'd2
  } cfg_idx_t;

  localparam int unsigned WIDTH_W = 12;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned ROLL_W  = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned TURN_W  = 4;
  localparam int unsigned INC_W   = 7;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned ROWS    = 9;

  // Signed working width: holds manual-mode sums and ramp under/overshoot
  localparam int unsigned SUM_W = 18;

  typedef logic [WIDTH_W-1:0]      width_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam width_t GUARD_HIGH_RST = 12'd2027;
  localparam width_t GUARD_LOW_RST  = 12'd737;
  localparam width_t CENTRE_RST     = 12'd1382;
  localparam width_t WING_R_START   = 12'd1151;
  localparam width_t WING_L_START   = 12'd1613;
  localparam width_t TAIL_BIAS      = 12'd1296;
  localparam width_t ROLL_BIAS      = 12'd691;

  // Configuration register set
  typedef struct packed {
    width_t guard_high;
    width_t guard_low;
    width_t centre;
  } cfg_t;

  // One input request
  typedef struct packed {
    logic [THR_W-1:0]  throttle_width;
    logic [ROLL_W-1:0] roll_width;
    logic              mode;
  } item_t;

  // One row of wing-cycle timing
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [CNT_W-1:0]   len;
    logic [TURN_W-1:0]  ta;
    logic [TURN_W-1:0]  tb;
    logic [INC_W-1:0]   inc;
    width_t             twr;
    width_t             twl;
  } row_t;

  localparam row_t ROW_TABLE [ROWS] = '{
    '{11'd1005, 5'd18, 4'd9, 4'd9, 7'd26, 12'd1382, 12'd1382},
    '{11'd1089, 5'd15, 4'd8, 4'd7, 7'd31, 12'd1397, 12'd1367},
    '{11'd1173, 5'd13, 4'd7, 4'd6, 7'd36, 12'd1400, 12'd1364},
    '{11'd1257, 5'd11, 4'd6, 4'd5, 7'd41, 12'd1402, 12'd1362},
    '{11'd1341, 5'd10, 4'd5, 4'd5, 7'd46, 12'd1382, 12'd1382},
    '{11'd1425, 5'd9,  4'd5, 4'd4, 7'd51, 12'd1407, 12'd1357},
    '{11'd1551, 5'd8,  4'd4, 4'd4, 7'd57, 12'd1382, 12'd1382},
    '{11'd1697, 5'd7,  4'd4, 4'd3, 7'd66, 12'd1415, 12'd1349},
    '{11'd1844, 5'd6,  4'd3, 4'd3, 7'd77, 12'd1382, 12'd1382}
  };

  // Wave generator state, also the source of the result fields
  typedef struct packed {
    logic              in_cycle;
    logic [CNT_W-1:0]  stroke_count;
    logic              stroke_down;
    logic              twist_down;
    logic [CNT_W-1:0]  cycle_length;
    logic [TURN_W-1:0] twist_turn_a;
    logic [TURN_W-1:0] twist_turn_b;
    logic [INC_W-1:0]  stroke_increment;
    width_t            wing_right;
    width_t            wing_left;
    width_t            twist_right;
    width_t            twist_left;
    width_t            tail;
  } state_t;

  localparam state_t STATE_RST = '{
    in_cycle:         1'b0,
    stroke_count:     5'd0,
    stroke_down:      1'b1,
    twist_down:       1'b1,
    cycle_length:     5'd18,
    twist_turn_a:     4'd9,
    twist_turn_b:     4'd9,
    stroke_increment: 7'd26,
    wing_right:       CENTRE_RST,
    wing_left:        CENTRE_RST,
    twist_right:      CENTRE_RST,
    twist_left:       CENTRE_RST,
    tail:             CENTRE_RST
  };

endpackage

/* rtl/fswg_in_if.sv */
// Input channel: one servo-frame tick with throttle, roll and mode.
interface fswg_in_if;
  import fswg_pkg::*;

  logic              valid;
  logic              ready;
  logic [THR_W-1:0]  throttle_width;
  logic [ROLL_W-1:0] roll_width;
  logic              mode;

  modport source (output valid, output throttle_width, output roll_width, output mode,
                  input ready);
  modport sink   (input valid, input throttle_width, input roll_width, input mode,
                  output ready);
endinterface

/* rtl/fswg_out_if.sv */
// Result channel: the five servo pulse widths of one tick.
interface fswg_out_if;
  import fswg_pkg::*;

  logic   valid;
  logic   ready;
  width_t wing_right;
  width_t wing_left;
  width_t twist_right;
  width_t twist_left;
  width_t tail_width;

  modport source (output valid, output wing_right, output wing_left, output twist_right,
                  output twist_left, output tail_width, input ready);
  modport sink   (input valid, input wing_right, input wing_left, input twist_right,
                  input twist_left, input tail_width, output ready);
endinterface

/* rtl/fswg_core.sv */
// Next-state logic of one tick: row latch, triangle ramps, manual scaling and guards.
module fswg_core
  import fswg_pkg::*;
(
  input  state_t st,
  input  item_t  item,
  input  cfg_t   cfg,
  output state_t st_nxt
);

  // High guard first, then low guard; both fall back to centre
  function automatic width_t guard(input sum_t v, input cfg_t c);
    sum_t g;
    g = v;
    if (g >= $signed({{(SUM_W-WIDTH_W){1'b0}}, c.guard_high}))
      g = $signed({{(SUM_W-WIDTH_W){1'b0}}, c.centre});
    if (g <= $signed({{(SUM_W-WIDTH_W){1'b0}}, c.guard_low}))
      g = $signed({{(SUM_W-WIDTH_W){1'b0}}, c.centre});
    return g[WIDTH_W-1:0];
  endfunction

  function automatic sum_t ext(input width_t w);
    return $signed({{(SUM_W-WIDTH_W){1'b0}}, w});
  endfunction

  row_t       row;
  logic       row_hit;
  state_t     s;
  sum_t       wr, wl, twr, twl, tl;
  sum_t       step, tstep;

  // First row whose limit is above the throttle
  always_comb begin
    row     = ROW_TABLE[0];
    row_hit = 1'b0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (item.throttle_width < {{(THR_W-LIMIT_W){1'b0}}, ROW_TABLE[r].limit}) begin
        row     = ROW_TABLE[r];
        row_hit = 1'b1;
      end
    end
  end

  always_comb begin
    s     = st;
    wr    = ext(st.wing_right);
    wl    = ext(st.wing_left);
    twr   = ext(st.twist_right);
    twl   = ext(st.twist_left);
    tl    = ext(st.tail);
    step  = '0;
    tstep = '0;

    if (item.mode) begin
      // Cycle start: latch a row unless no row limit is above the throttle
      if (!st.in_cycle) begin
        if (row_hit) begin
          s.cycle_length     = row.len;
          s.twist_turn_a     = row.ta;
          s.twist_turn_b     = row.tb;
          s.stroke_increment = row.inc;
          twr                = ext(row.twr);
          twl                = ext(row.twl);
          tl                 = ext(CENTRE_RST);
        end
        s.in_cycle     = 1'b1;
        wr             = ext(WING_R_START);
        wl             = ext(WING_L_START);
        s.stroke_count = '0;
      end

      step  = $signed({{(SUM_W-INC_W){1'b0}}, s.stroke_increment});
      tstep = $signed({{(SUM_W-INC_W+3){1'b0}}, s.stroke_increment[INC_W-1:3]});

      // Stroke triangle
      if (s.stroke_down) begin
        wr             = wr + step;
        wl             = wl - step;
        s.stroke_count = s.stroke_count + 1'b1;
      end else begin
        wr             = wr - step;
        wl             = wl + step;
        s.stroke_count = s.stroke_count - 1'b1;
      end

      // Twist and tail triangle
      if (s.twist_down) begin
        tl  = tl - tstep;
        twr = twr - step;
        twl = twl + step;
      end else begin
        tl  = tl + tstep;
        twr = twr + step;
        twl = twl - step;
      end

      // Turn points
      if (s.twist_down && s.stroke_count == {1'b0, s.twist_turn_a})
        s.twist_down = 1'b0;
      else if (!s.twist_down && s.stroke_count == {1'b0, s.twist_turn_b})
        s.twist_down = 1'b1;
      if (s.stroke_count == s.cycle_length)
        s.stroke_down = 1'b0;
      if (s.stroke_count == '0) begin
        s.in_cycle    = 1'b0;
        s.stroke_down = 1'b1;
      end
    end else begin
      // Manual pass-through with scaling
      tl  = $signed({{(SUM_W-THR_W+4){1'b0}}, item.throttle_width[THR_W-1:4]}) + ext(TAIL_BIAS);
      wr  = $signed({{(SUM_W-ROLL_W+1){1'b0}}, item.roll_width[ROLL_W-1:1]}) + ext(ROLL_BIAS);
      wl  = wr;
      twr = ext(cfg.centre);
      twl = ext(cfg.centre);
    end

    s.wing_right  = guard(wr, cfg);
    s.wing_left   = guard(wl, cfg);
    s.twist_right = guard(twr, cfg);
    s.twist_left  = guard(twl, cfg);
    s.tail        = guard(tl, cfg);
    st_nxt        = s;
  end

endmodule

/* rtl/flapping_servo_wave_generator.sv */
// Top level of the flapping servo wave generator: input stage, state/result register, config.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    throttle_width[15:0], roll_width[15:0], mode
//   out_ch    out   valid/ready    wing_right, wing_left, twist_right, twist_left, tail_width
//   cfg_*     in    write enable   cfg_index[1:0], cfg_data[11:0]
//
// One request per cycle sustained while out_ch does not stall; a request passes the input register, then the
// state register that also serves as the result register, fed by one pass of fswg_core.
// Reset is synchronous (rst_n low): slowest row, all widths at centre, default guards.
// When out_ch stalls the result holds and the input register fills, then in_ch.ready drops.
module flapping_servo_wave_generator
  import fswg_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  fswg_in_if.sink        in_ch,
  fswg_out_if.source     out_ch,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [WIDTH_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  item_t  item_r;
  logic   item_valid_r;
  state_t st_r, st_nxt;
  logic   out_valid_r;
  logic   res_ready, item_ready, advance;

  assign res_ready  = !out_valid_r || out_ch.ready;
  assign item_ready = !item_valid_r || res_ready;
  assign advance    = item_valid_r && res_ready;
  assign in_ch.ready = item_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.guard_high <= GUARD_HIGH_RST;
      cfg_r.guard_low  <= GUARD_LOW_RST;
      cfg_r.centre     <= CENTRE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GUARD_HIGH: cfg_r.guard_high <= cfg_data;
        CFG_GUARD_LOW:  cfg_r.guard_low  <= cfg_data;
        CFG_CENTRE:     cfg_r.centre     <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (item_ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && in_ch.valid) begin
      item_r.throttle_width <= in_ch.throttle_width;
      item_r.roll_width     <= in_ch.roll_width;
      item_r.mode           <= in_ch.mode;
    end
  end

  fswg_core u_core (
    .st     (st_r),
    .item   (item_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt)
  );

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (res_ready) begin
        out_valid_r <= item_valid_r;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.wing_right  = st_r.wing_right;
  assign out_ch.wing_left   = st_r.wing_left;
  assign out_ch.twist_right = st_r.twist_right;
  assign out_ch.twist_left  = st_r.twist_left;
  assign out_ch.tail_width  = st_r.tail;

endmodule
